>>> hdl/ffha_pkg.sv
package ffha_pkg;

    localparam int unsigned CMD_W     = 1;
    localparam int unsigned REQ_W     = 13;
    localparam int unsigned PAY_W     = 12;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned GRANT_W   = 12;

    // smallest payload a block may carry
    localparam int unsigned MIN_PAYLOAD = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_OOM  = 2'd1,
        ST_NULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_MERGE,
        S_SPLIT,
        S_MARK,
        S_RESP
    } t_state;

endpackage

>>> hdl/ffha_if.sv
interface ffha_req_if import ffha_pkg::*; ();
    logic               valid;
    logic               ready;
    t_cmd               command;
    logic [REQ_W-1:0]   request_bytes;
    logic [PAY_W-1:0]   payload_offset;

    modport source (output valid, command, request_bytes, payload_offset, input ready);
    modport sink   (input valid, command, request_bytes, payload_offset, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
    logic               valid;
    logic               ready;
    t_status            status;
    logic [GRANT_W-1:0] granted_offset;

    modport source (output valid, status, granted_offset, input ready);
    modport sink   (input valid, status, granted_offset, output ready);
endinterface

>>> hdl/ffha_ram.sv
module ffha_ram #(
    parameter int unsigned WIDTH = 14,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

>>> hdl/first_fit_heap_allocator_core.sv
// First-fit heap allocator core.
// Request channel i_req carries one beat per command: allocate (request_bytes)
// or free (payload_offset). Response channel o_rsp returns exactly one beat per
// request: status and, for a successful allocate, the granted payload offset.
// The block headers live in a single-port-write, registered-read RAM; the
// controller walks the header chain one header per cycle.
// Steps per request: an allocate walks the headers until one fits, writes
// a remainder header when the block is split, marks the block used and
// responds; when the walk runs off the heap it responds out of memory. A
// free walks to the target header, then reads and absorbs the free headers
// after it (up to the used one that stops the merge), marks the block free
// and responds; a stray free responds once its walk fails, and a null free
// responds straight away. Requests are served one at a time; the next one is
// taken only once the controller is back in idle, with the result already in
// the output register.
// Reset leaves a single free block spanning the heap; header 0 is overridden
// by a flag until first written, so no clearing pass runs.
// When the receiver stalls, the result waits in the output register; a new
// request may still be taken and processed, and it holds in its final state
// until the output register frees up.
module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int unsigned HEAP_BYTES   = 4096,
    parameter int unsigned HEADER_BYTES = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffha_req_if.sink    i_req,
    ffha_rsp_if.source  o_rsp
);

    localparam int unsigned ADDR_W  = $clog2(HEAP_BYTES);
    localparam int unsigned OFF_W   = $clog2(HEAP_BYTES + 1);
    localparam int unsigned CAP_W   = OFF_W;
    localparam int unsigned ENTRY_W = CAP_W + 1;
    localparam int unsigned SUM_W   = ((OFF_W > REQ_W + 1) ? OFF_W : REQ_W + 1) + 1;

    localparam logic [SUM_W-1:0] HDR    = SUM_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0] HEAP_X = SUM_W'(HEAP_BYTES);
    localparam logic [SUM_W-1:0] MIN_X  = SUM_W'(MIN_PAYLOAD);
    localparam logic [CAP_W-1:0] CAP0   = CAP_W'(HEAP_BYTES - HEADER_BYTES);

    // a header starting at x lies inside the heap
    function automatic logic block_ok(input logic [SUM_W-1:0] x);
        return (x + HDR) <= HEAP_X;
    endfunction

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [REQ_W-1:0]   r_q, n_q;
    logic [PAY_W-1:0]   r_target, n_target;
    logic [SUM_W-1:0]   r_off, n_off;
    logic [SUM_W-1:0]   r_nx, n_nx;
    logic [CAP_W-1:0]   r_cap_new, n_cap_new;
    logic [CAP_W-1:0]   r_cap_rest, n_cap_rest;
    t_status            r_res_status, n_res_status;
    logic [GRANT_W-1:0] r_res_grant, n_res_grant;
    logic               r_hdr0_valid, n_hdr0_valid;
    logic               r_rd_addr0, n_rd_addr0;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [GRANT_W-1:0] r_out_grant, n_out_grant;

    // RAM ports
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

    ffha_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HEAP_BYTES)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // header read back: offset 0 reads as the whole-heap block until written
    logic               hdr_free;
    logic [CAP_W-1:0]   hdr_cap;
    logic [SUM_W-1:0]   cap_x, q_x, tgt_x;
    logic [SUM_W-1:0]   nxt_walk, nxt_merge;
    logic               fits, split_ok, in_beat, out_free;

    always_comb begin
        if (r_rd_addr0 && !r_hdr0_valid) begin
            hdr_free = 1'b1;
            hdr_cap  = CAP0;
        end else begin
            hdr_free = mem_rdata[ENTRY_W-1];
            hdr_cap  = mem_rdata[CAP_W-1:0];
        end
    end

    assign cap_x     = SUM_W'(hdr_cap);
    assign q_x       = SUM_W'(r_q);
    assign tgt_x     = SUM_W'(r_target);
    assign nxt_walk  = r_off + HDR + cap_x;
    assign nxt_merge = r_nx + HDR + cap_x;
    assign fits      = hdr_free && (cap_x >= q_x);
    assign split_ok  = (q_x + HDR + MIN_X) <= cap_x;
    assign in_beat   = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if (i_req.command == CMD_FREE &&
                        i_req.payload_offset < PAY_W'(HEADER_BYTES)) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_cmd == CMD_ALLOC) begin
                    priority if (fits) begin
                        n_state = split_ok ? S_SPLIT : S_MARK;
                    end else if (!block_ok(nxt_walk)) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_WALK;
                    end
                end else begin
                    priority if (r_off == tgt_x) begin
                        n_state = block_ok(nxt_walk) ? S_MERGE : S_MARK;
                    end else if (r_off > tgt_x || !block_ok(nxt_walk)) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_MERGE: begin
                if (!hdr_free || !block_ok(nxt_merge)) begin
                    n_state = S_MARK;
                end
            end
            S_SPLIT: n_state = S_MARK;
            S_MARK:  n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd        = r_cmd;
        n_q          = r_q;
        n_target     = r_target;
        n_off        = r_off;
        n_nx         = r_nx;
        n_cap_new    = r_cap_new;
        n_cap_rest   = r_cap_rest;
        n_res_status = r_res_status;
        n_res_grant  = r_res_grant;
        n_hdr0_valid = r_hdr0_valid;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_grant  = r_out_grant;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        i_req.ready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (in_beat) begin
                    n_cmd        = i_req.command;
                    n_q          = (i_req.request_bytes < REQ_W'(MIN_PAYLOAD)) ?
                                   REQ_W'(MIN_PAYLOAD) : i_req.request_bytes;
                    n_target     = i_req.payload_offset - PAY_W'(HEADER_BYTES);
                    n_off        = '0;
                    n_res_status = ST_NULL;
                    n_res_grant  = '0;
                    mem_re       = 1'b1;
                end
            end
            S_WALK: begin
                if (r_cmd == CMD_ALLOC) begin
                    priority if (fits) begin
                        n_cap_new  = split_ok ? r_q[CAP_W-1:0] : hdr_cap;
                        n_cap_rest = CAP_W'(cap_x - q_x - HDR);
                    end else if (block_ok(nxt_walk)) begin
                        n_off     = nxt_walk;
                        mem_re    = 1'b1;
                        mem_raddr = nxt_walk[ADDR_W-1:0];
                    end else begin
                        n_res_status = ST_OOM;
                    end
                end else begin
                    priority if (r_off == tgt_x) begin
                        n_cap_new = hdr_cap;
                        n_nx      = nxt_walk;
                        if (block_ok(nxt_walk)) begin
                            mem_re    = 1'b1;
                            mem_raddr = nxt_walk[ADDR_W-1:0];
                        end
                    end else if (r_off < tgt_x && block_ok(nxt_walk)) begin
                        n_off     = nxt_walk;
                        mem_re    = 1'b1;
                        mem_raddr = nxt_walk[ADDR_W-1:0];
                    end else begin
                        // offset names no block
                        n_res_status = ST_NULL;
                    end
                end
            end
            S_MERGE: begin
                if (hdr_free) begin
                    n_cap_new = CAP_W'(SUM_W'(r_cap_new) + HDR + cap_x);
                    n_nx      = nxt_merge;
                    if (block_ok(nxt_merge)) begin
                        mem_re    = 1'b1;
                        mem_raddr = nxt_merge[ADDR_W-1:0];
                    end
                end
            end
            S_SPLIT: begin
                // remainder header right after the shrunk payload
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(r_off + HDR + q_x);
                mem_wdata = {1'b1, r_cap_rest};
            end
            S_MARK: begin
                mem_we       = 1'b1;
                mem_waddr    = r_off[ADDR_W-1:0];
                mem_wdata    = {(r_cmd == CMD_FREE), r_cap_new};
                n_res_status = ST_DONE;
                n_res_grant  = (r_cmd == CMD_ALLOC) ? GRANT_W'(r_off + HDR) : '0;
                if (r_off == '0) begin
                    n_hdr0_valid = 1'b1;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_grant  = r_res_grant;
                end
            end
            default: ;
        endcase
    end

    assign n_rd_addr0 = mem_re && (mem_raddr == '0);

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.granted_offset = r_out_grant;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hdr0_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_rd_addr0   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hdr0_valid <= n_hdr0_valid;
            r_out_valid  <= n_out_valid;
            r_rd_addr0   <= n_rd_addr0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_q          <= n_q;
        r_target     <= n_target;
        r_off        <= n_off;
        r_nx         <= n_nx;
        r_cap_new    <= n_cap_new;
        r_cap_rest   <= n_cap_rest;
        r_res_status <= n_res_status;
        r_res_grant  <= n_res_grant;
        r_out_status <= n_out_status;
        r_out_grant  <= n_out_grant;
    end

endmodule

>>> hdl/ffha_checker.sv
module ffha_checker
    import ffha_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic [STATUS_W-1:0] i_rsp_status,
    input logic [GRANT_W-1:0]  i_rsp_grant
);

    // one request in flight: no new beat taken in the cycle after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken on consecutive cycles");

    // only a successful beat carries an offset
    a_grant_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != ST_DONE) |-> (i_rsp_grant == '0))
        else $error("offset on a failed or ignored response");

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_grant)))
        else $error("response dropped or changed under stall");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_grant  (o_rsp.granted_offset)
);

>>> dv/tb_first_fit_heap_allocator_core.sv
module tb_first_fit_heap_allocator_core;
    import ffha_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HEAP_BYTES   = 4096;
    localparam int unsigned HEADER_BYTES = 17;
    // generous upper bound for the slowest correct run
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    // worst single request: a full header walk plus a full merge
    localparam int unsigned TAIL_CYCLES  = 300;
    localparam int unsigned MAX_GAP      = 20;

    typedef struct packed {
        t_status            status;
        logic [GRANT_W-1:0] granted_offset;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    ffha_req_if req_if ();
    ffha_rsp_if rsp_if ();

    first_fit_heap_allocator_core #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Our own copy of the heap: header capacity and free mark per byte offset.
    // Only offsets that start a block in the chain are ever looked at.
    int unsigned hdr_cap  [HEAP_BYTES];
    bit          hdr_free [HEAP_BYTES];

    t_result     awaited_results [$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Heap bookkeeping, mirroring the block's first-fit behaviour
    // ------------------------------------------------------------------
    task automatic heap_clear();
        for (int unsigned i = 0; i < HEAP_BYTES; i++) begin
            hdr_cap[i]  = 0;
            hdr_free[i] = 1'b0;
        end
        // one free block covering the whole heap
        hdr_cap[0]  = HEAP_BYTES - HEADER_BYTES;
        hdr_free[0] = 1'b1;
    endtask

    // Returns the payload offset of the block taken, zero when nothing fits.
    function automatic logic [GRANT_W-1:0] first_fit_take(input int unsigned req_bytes);
        int unsigned        want;
        int unsigned        off;
        int unsigned        rest;
        logic [GRANT_W-1:0] grant;
        want  = (req_bytes < MIN_PAYLOAD) ? MIN_PAYLOAD : req_bytes;
        off   = 0;
        grant = '0;
        while (off + HEADER_BYTES <= HEAP_BYTES) begin
            if (hdr_free[off] && hdr_cap[off] >= want) begin
                // split only if the tail can carry a header and a minimum payload
                if (want + HEADER_BYTES + MIN_PAYLOAD <= hdr_cap[off]) begin
                    rest           = off + HEADER_BYTES + want;
                    hdr_cap[rest]  = hdr_cap[off] - want - HEADER_BYTES;
                    hdr_free[rest] = 1'b1;
                    hdr_cap[off]   = want;
                end
                hdr_free[off] = 1'b0;
                grant         = GRANT_W'(off + HEADER_BYTES);
                return grant;
            end
            off = off + HEADER_BYTES + hdr_cap[off];
        end
        return grant;
    endfunction

    // Frees the block whose payload sits at pay_off and absorbs any free
    // blocks that follow it. Returns 0 when pay_off names no block.
    function automatic bit release_and_coalesce(input int unsigned pay_off);
        int unsigned target;
        int unsigned off;
        int unsigned nxt;
        if (pay_off < HEADER_BYTES) return 1'b0;
        target = pay_off - HEADER_BYTES;
        off    = 0;
        while (off + HEADER_BYTES <= HEAP_BYTES && off < target)
            off = off + HEADER_BYTES + hdr_cap[off];
        if (off + HEADER_BYTES > HEAP_BYTES || off != target) return 1'b0;
        hdr_free[off] = 1'b1;
        forever begin
            nxt = off + HEADER_BYTES + hdr_cap[off];
            if (nxt + HEADER_BYTES > HEAP_BYTES || !hdr_free[nxt]) break;
            hdr_cap[off] += HEADER_BYTES + hdr_cap[nxt];
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Request side. Inputs move on the falling edge only; a beat is taken
    // at the rising edge that sees valid and ready high together. The
    // field a command does not use is filled with noise.
    // ------------------------------------------------------------------
    task automatic issue(input t_cmd cmd, input int unsigned req_bytes,
                         input int unsigned pay_off, output logic [GRANT_W-1:0] grant);
        int unsigned gap;
        t_result     outcome;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid   <= 1'b1;
        req_if.command <= cmd;
        if (cmd == CMD_ALLOC) begin
            req_if.request_bytes  <= req_bytes[REQ_W-1:0];
            req_if.payload_offset <= PAY_W'($urandom_range(HEAP_BYTES - 1));
        end else begin
            req_if.request_bytes  <= REQ_W'($urandom_range(HEAP_BYTES));
            req_if.payload_offset <= pay_off[PAY_W-1:0];
        end
        do @(posedge i_clk); while (!req_if.ready);

        // beat accepted: work out what the block must answer
        if (cmd == CMD_ALLOC) begin
            grant                  = first_fit_take(req_bytes);
            outcome.status         = (grant != '0) ? ST_DONE : ST_OOM;
            outcome.granted_offset = grant;
        end else begin
            grant                  = '0;
            outcome.status         = release_and_coalesce(pay_off) ? ST_DONE : ST_NULL;
            outcome.granted_offset = '0;
        end
        awaited_results.push_back(outcome);
    endtask

    // Stop sending and hold off until every outstanding answer is back.
    task automatic settle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: random back-pressure, checked against the oldest
    // outstanding answer on each accepted beat.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (awaited_results.size() == 0) begin
                $error("response beat with nothing outstanding: status %0d offset %0d",
                       rsp_if.status, rsp_if.granted_offset);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    mismatch_count++;
                end
                if (rsp_if.granted_offset !== want.granted_offset) begin
                    $error("granted_offset: expected %0d, got %0d",
                           want.granted_offset, rsp_if.granted_offset);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    logic [GRANT_W-1:0] small_grants [5];

    // Tiny and zero sizes round up to the minimum; a whole-heap request
    // cannot fit, since even a single block holds at most the heap less one header.
    task automatic test_size_extremes();
        logic [GRANT_W-1:0] g;
        issue(CMD_ALLOC, 0,          0, small_grants[0]);
        issue(CMD_ALLOC, 1,          0, small_grants[1]);
        issue(CMD_ALLOC, 23,         0, small_grants[2]);
        issue(CMD_ALLOC, 24,         0, small_grants[3]);
        issue(CMD_ALLOC, 25,         0, small_grants[4]);
        issue(CMD_ALLOC, HEAP_BYTES, 0, g);
    endtask

    // Null pointers and offsets that are not the start of any payload
    // must leave the heap alone.
    task automatic test_null_and_stray_frees();
        logic [GRANT_W-1:0] g;
        issue(CMD_FREE, 0, 0,                   g);
        issue(CMD_FREE, 0, HEADER_BYTES - 1,    g);
        issue(CMD_FREE, 0, HEAP_BYTES - 1,      g);
        issue(CMD_FREE, 0, small_grants[0] + 1, g);
    endtask

    // A double free still succeeds; freeing in reverse address order makes
    // each block soak up everything after it, ending with one whole heap.
    task automatic test_double_free_and_merge();
        logic [GRANT_W-1:0] g;
        issue(CMD_FREE, 0, small_grants[0], g);
        issue(CMD_FREE, 0, small_grants[0], g);
        for (int i = 4; i >= 0; i--)
            issue(CMD_FREE, 0, small_grants[i], g);
    endtask

    // Exact fit of the whole heap (no split), then a split that leaves a
    // tail of exactly the minimum payload, which a minimum request then takes.
    task automatic test_whole_heap_fit();
        logic [GRANT_W-1:0] whole;
        logic [GRANT_W-1:0] big;
        logic [GRANT_W-1:0] tail;
        logic [GRANT_W-1:0] g;
        issue(CMD_ALLOC, HEAP_BYTES - HEADER_BYTES, 0, whole);
        issue(CMD_ALLOC, 0,                         0, g);
        issue(CMD_FREE,  0,                         whole, g);
        issue(CMD_ALLOC, HEAP_BYTES - 2 * HEADER_BYTES - MIN_PAYLOAD, 0, big);
        issue(CMD_ALLOC, MIN_PAYLOAD,               0, tail);
        issue(CMD_FREE,  0,                         tail, g);
        issue(CMD_FREE,  0,                         big, g);
    endtask

    // Mostly well-formed alloc/free churn on live blocks, with repeated
    // frees, null frees and stray offsets mixed in.
    task automatic test_random_churn(input int unsigned n_items,
                                     input int unsigned idle_pct,
                                     input int unsigned stall_pct);
        logic [GRANT_W-1:0] live_blocks [$];
        logic [GRANT_W-1:0] freed_blocks [$];
        logic [GRANT_W-1:0] g;
        int unsigned        pick;
        int unsigned        roll;
        int unsigned        size_roll;
        int unsigned        nbytes;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int unsigned k = 0; k < n_items; k++) begin
            roll = $urandom_range(99);
            if (live_blocks.size() != 0 && roll < 42) begin
                pick = $urandom_range(live_blocks.size() - 1);
                issue(CMD_FREE, 0, live_blocks[pick], g);
                freed_blocks.push_back(live_blocks[pick]);
                if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
                live_blocks.delete(pick);
            end else if (freed_blocks.size() != 0 && roll < 50) begin
                issue(CMD_FREE, 0, freed_blocks[$urandom_range(freed_blocks.size() - 1)], g);
            end else if (roll < 55) begin
                issue(CMD_FREE, 0, $urandom_range(HEADER_BYTES - 1), g);
            end else if (roll < 60) begin
                issue(CMD_FREE, 0, $urandom_range(HEAP_BYTES - 1), g);
            end else begin
                size_roll = $urandom_range(99);
                if (size_roll < 50)      nbytes = $urandom_range(64);
                else if (size_roll < 85) nbytes = $urandom_range(400, 65);
                else if (size_roll < 97) nbytes = $urandom_range(1500, 401);
                else                     nbytes = $urandom_range(HEAP_BYTES, 1501);
                issue(CMD_ALLOC, nbytes, 0, g);
                if (g != '0) live_blocks.push_back(g);
            end
        end
        // everything must be back before the idling pattern changes
        settle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.command        = CMD_ALLOC;
        req_if.request_bytes  = '0;
        req_if.payload_offset = '0;
        rsp_if.ready          = 1'b1;
        mismatch_count        = 0;
        cycle_count           = 0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        heap_clear();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_size_extremes();
        test_null_and_stray_frees();
        test_double_free_and_merge();
        test_whole_heap_fit();
        settle();

        test_random_churn(125, 0,  0);
        test_random_churn(125, 76, 0);
        test_random_churn(125, 0,  76);
        test_random_churn(125, 21, 21);

        // let anything unexpected surface before judging
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
